[rtl/assert_macros.svh]
// Assertion macros shared by the segmentation block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SGSM_ASSERT_NOW(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition at one edge implies a result at the next edge.
`define SGSM_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) else $error(msg);

`endif

[rtl/sgsm_pkg.sv]
// Shared constants and types of the scan gap segmentation block.
package sgsm_pkg;

	// Widths fixed by the interface.
	localparam int GAP_W = 17;

	// Default geometry.
	localparam int COORD_BITS_DEF  = 18;
	localparam int MAX_OBJECTS_DEF = 1024;

	// Gap threshold after reset (6.0 m in Q9.8) and its square.
	localparam logic [GAP_W-1:0]   GAP_RESET    = GAP_W'(1536);
	localparam logic [2*GAP_W-1:0] GAP_SQ_RESET = (2*GAP_W)'(1536 * 1536);

	// Depth of the object queue; it must be a power of two of at least four.
	localparam int OBJ_FIFO_DEPTH = 4;

	// Objects written into the queue by one point.
	typedef struct packed {
		logic gap_obj;    // segment closed by a gap
		logic final_obj;  // last segment of the scan
	} sgsm_push_t;

endpackage

[rtl/sgsm_obj_fifo.sv]
// Small object queue that takes up to two objects per cycle and gives one while the consumer is ready.
`include "assert_macros.svh"

module sgsm_obj_fifo #(
	parameter int DATA_W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sgsm_pkg::sgsm_push_t push,
	input  logic [DATA_W-1:0]   data_a,
	input  logic [DATA_W-1:0]   data_b,
	output logic                space_ok,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   out_data
);

	localparam int DEPTH = sgsm_pkg::OBJ_FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  wr_ptr_p1;
	logic [CNT_W-1:0]  n_push;
	logic              pop;
	logic              any_push;

	// Push and pop bookkeeping.
	assign n_push    = CNT_W'(push.gap_obj) + CNT_W'(push.final_obj);
	assign any_push  = push.gap_obj | push.final_obj;
	assign pop       = out_valid & out_ready;
	assign wr_ptr_p1 = PTR_W'(wr_ptr_q + 1'b1);
	assign space_ok  = (count_q <= CNT_W'(DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];

	// Storage: the gap object goes first, the final object after it.
	always_ff @(posedge clk) begin
		if (push.gap_obj) begin
			mem_q[wr_ptr_q] <= data_a;
			if (push.final_obj) begin
				mem_q[wr_ptr_p1] <= data_b;
			end
		end else if (push.final_obj) begin
			mem_q[wr_ptr_q] <= data_b;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + n_push[PTR_W-1:0]);
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_q + n_push - CNT_W'(pop));
		end
	end

	`SGSM_ASSERT_NOW(a_fifo_bound, count_q <= CNT_W'(DEPTH), "object queue overflow")
	`SGSM_ASSERT_NOW(a_push_room, !any_push || (count_q <= CNT_W'(DEPTH - 2)), "push without room")

endmodule

[rtl/sgsm_point_proc.sv]
// Input register, segment state and gap test for one point per cycle while the queue has room.
`include "assert_macros.svh"

module sgsm_point_proc #(
	parameter int COORD_BITS  = sgsm_pkg::COORD_BITS_DEF,
	parameter int MAX_OBJECTS = sgsm_pkg::MAX_OBJECTS_DEF,
	parameter int IDX_W       = $clog2(MAX_OBJECTS),
	parameter int OBJ_W       = 3 * COORD_BITS + IDX_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic signed [COORD_BITS-1:0] z_coord,
	input  logic                         scan_start,
	input  logic                         scan_end,
	input  logic                         cfg_we,
	input  logic [sgsm_pkg::GAP_W-1:0]   cfg_wdata,
	input  logic                         space_ok,
	output sgsm_pkg::sgsm_push_t         push,
	output logic [OBJ_W-1:0]             obj_a,
	output logic [OBJ_W-1:0]             obj_b
);

	localparam int GAP_W  = sgsm_pkg::GAP_W;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int EXT_W  = (DIFF_W > GAP_W) ? DIFF_W : GAP_W;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_OBJECTS - 1);

	// Point register.
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic                         start_s1, end_s1;

	// Segment state and configuration.
	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, start_z_q;
	logic signed [COORD_BITS-1:0] end_x_q, end_y_q;
	logic                         in_scan_q;
	logic [IDX_W-1:0]             count_q;
	logic [GAP_W-1:0]             gap_q;
	logic [2*GAP_W-1:0]           thr_sq_q;

	// Datapath signals.
	logic                         go, active, joins, gap;
	logic signed [DIFF_W-1:0]     dx, dy;
	logic [DIFF_W-1:0]            adx, ady;
	logic [EXT_W-1:0]             adx_ext, ady_ext, gap_ext;
	logic [GAP_W-1:0]             adx_n, ady_n;
	logic [2*GAP_W-1:0]           sq_x, sq_y;
	logic [2*GAP_W:0]             sum_sq;
	logic signed [DIFF_W-1:0]     sum_ax, sum_ay, sum_bx, sum_by;
	logic signed [COORD_BITS-1:0] fs_x, fs_y, fs_z;
	logic [IDX_W-1:0]             count_b, count_next;

	function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] c);
		sat_inc = (c == IDX_MAX) ? c : IDX_W'(c + 1'b1);
	endfunction

	// Handshake: a held point moves on when the queue has room for two objects.
	assign go       = valid_s1 & space_ok;
	assign in_ready = !valid_s1 | go;
	assign active   = start_s1 | in_scan_q;

	// Planar gap test against the segment's last point.
	assign dx      = DIFF_W'(x_s1) - DIFF_W'(end_x_q);
	assign dy      = DIFF_W'(y_s1) - DIFF_W'(end_y_q);
	assign adx     = dx[DIFF_W-1] ? $unsigned(-dx) : $unsigned(dx);
	assign ady     = dy[DIFF_W-1] ? $unsigned(-dy) : $unsigned(dy);
	assign adx_ext = EXT_W'(adx);
	assign ady_ext = EXT_W'(ady);
	assign gap_ext = EXT_W'(gap_q);
	assign adx_n   = adx_ext[GAP_W-1:0];
	assign ady_n   = ady_ext[GAP_W-1:0];
	assign sq_x    = (2*GAP_W)'(adx_n) * (2*GAP_W)'(adx_n);
	assign sq_y    = (2*GAP_W)'(ady_n) * (2*GAP_W)'(ady_n);
	assign sum_sq  = {1'b0, sq_x} + {1'b0, sq_y};
	assign joins   = (adx_ext < gap_ext) && (ady_ext < gap_ext) && (sum_sq < {1'b0, thr_sq_q});
	assign gap     = !start_s1 && in_scan_q && !joins;

	// Segment that is open after this point; its end is always the point.
	assign fs_x = (start_s1 || gap) ? x_s1 : start_x_q;
	assign fs_y = (start_s1 || gap) ? y_s1 : start_y_q;
	assign fs_z = (start_s1 || gap) ? z_s1 : start_z_q;

	// Object numbers in order of emission.
	assign count_b    = gap ? sat_inc(count_q) : (start_s1 ? '0 : count_q);
	assign count_next = end_s1 ? sat_inc(count_b) : count_b;

	// Midpoints by floor halving of the sums.
	assign sum_ax = DIFF_W'(start_x_q) + DIFF_W'(end_x_q);
	assign sum_ay = DIFF_W'(start_y_q) + DIFF_W'(end_y_q);
	assign sum_bx = DIFF_W'(fs_x) + DIFF_W'(x_s1);
	assign sum_by = DIFF_W'(fs_y) + DIFF_W'(y_s1);

	assign obj_a = {sum_ax[DIFF_W-1:1], sum_ay[DIFF_W-1:1], start_z_q, count_q, 1'b0};
	assign obj_b = {sum_bx[DIFF_W-1:1], sum_by[DIFF_W-1:1], fs_z, count_b, 1'b1};

	assign push.gap_obj   = go & gap;
	assign push.final_obj = go & active & end_s1;

	// Point payload and segment coordinates.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1     <= x_coord;
			y_s1     <= y_coord;
			z_s1     <= z_coord;
			start_s1 <= scan_start;
			end_s1   <= scan_end;
		end
		if (go && active) begin
			start_x_q <= fs_x;
			start_y_q <= fs_y;
			start_z_q <= fs_z;
			end_x_q   <= x_s1;
			end_y_q   <= y_s1;
		end
	end

	// Control state and the threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			in_scan_q <= 1'b0;
			count_q   <= '0;
			gap_q     <= sgsm_pkg::GAP_RESET;
			thr_sq_q  <= sgsm_pkg::GAP_SQ_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go && active) begin
				in_scan_q <= !end_s1;
				count_q   <= count_next;
			end
			if (cfg_we) begin
				gap_q    <= cfg_wdata;
				thr_sq_q <= (2*GAP_W)'(cfg_wdata) * (2*GAP_W)'(cfg_wdata);
			end
		end
	end

	`SGSM_ASSERT_NOW(a_gap_in_scan, !push.gap_obj || (in_scan_q && !start_s1), "gap outside scan")
	`SGSM_ASSERT_NEXT(a_final_closes, push.final_obj, !in_scan_q, "scan left open")

endmodule

[rtl/scan_gap_segment_midpoints_unit.sv]
// Top level of the lidar scan gap segmentation block.
//
// Points of a scan enter one per cycle while the queue has room; a point
// that joins the open segment or opens a scan gives no object, a gap gives
// one, and the scan's last point gives the final object as well. A point is
// held in one input register and tested there against the segment state, so
// with an empty queue its first object passes from that register into the
// queue and is offered on the output from there. The block sustains one
// point per cycle while the queue has room for two objects; the output side
// moves one object per cycle through a four-entry queue when the consumer is
// ready, so a point that closes two objects at once can hold back the input.
// The gap threshold may be written only while no points are in flight.

module scan_gap_segment_midpoints_unit #(
	parameter int COORD_BITS  = sgsm_pkg::COORD_BITS_DEF,
	parameter int MAX_OBJECTS = sgsm_pkg::MAX_OBJECTS_DEF,
	parameter int IDX_W       = $clog2(MAX_OBJECTS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic signed [COORD_BITS-1:0] z_coord,
	input  logic                         scan_start,
	input  logic                         scan_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] obj_x,
	output logic signed [COORD_BITS-1:0] obj_y,
	output logic signed [COORD_BITS-1:0] obj_z,
	output logic [IDX_W-1:0]             obj_index,
	output logic                         final_object,
	input  logic                         cfg_we,
	input  logic [sgsm_pkg::GAP_W-1:0]   cfg_wdata
);

	localparam int OBJ_W = 3 * COORD_BITS + IDX_W + 1;

	sgsm_pkg::sgsm_push_t push;
	logic [OBJ_W-1:0]     obj_a, obj_b, obj_head;
	logic                 space_ok;

	// Segment tracking and gap test.
	sgsm_point_proc #(
		.COORD_BITS  (COORD_BITS),
		.MAX_OBJECTS (MAX_OBJECTS),
		.IDX_W       (IDX_W),
		.OBJ_W       (OBJ_W)
	) u_proc (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.scan_start (scan_start),
		.scan_end   (scan_end),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.space_ok   (space_ok),
		.push       (push),
		.obj_a      (obj_a),
		.obj_b      (obj_b)
	);

	// Object queue toward the consumer.
	sgsm_obj_fifo #(
		.DATA_W (OBJ_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_a    (obj_a),
		.data_b    (obj_b),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (obj_head)
	);

	// Unpack the head object into its fields.
	assign obj_x        = obj_head[OBJ_W-1 -: COORD_BITS];
	assign obj_y        = obj_head[OBJ_W-1-COORD_BITS -: COORD_BITS];
	assign obj_z        = obj_head[OBJ_W-1-2*COORD_BITS -: COORD_BITS];
	assign obj_index    = obj_head[IDX_W:1];
	assign final_object = obj_head[0];

endmodule
